@@ hw/rtl/rdd_pkg.sv @@
// Shared types and constants of the resource deadlock detector.
package rdd_pkg;

	localparam int TYPE_W   = 3;
	localparam int THREAD_W = 3;
	localparam int RES_W    = 2;
	localparam int AMT_W    = 8;
	localparam int MASK_W   = 8;
	localparam int TOTAL_W  = 16;
	localparam int POLICY_W = 3;

	localparam logic [TYPE_W-1:0] REQ_SET_NEED = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_ACQUIRE  = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_RELEASE  = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_SET_FREE = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_DETECT   = 3'd4;

	localparam logic [POLICY_W-1:0] POL_ALL      = 3'd0;
	localparam logic [POLICY_W-1:0] POL_FIRST    = 3'd1;
	localparam logic [POLICY_W-1:0] POL_MAX_NEED = 3'd2;
	localparam logic [POLICY_W-1:0] POL_MAX_HOLD = 3'd3;
	localparam logic [POLICY_W-1:0] POL_MIN_HOLD = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET_NEED,
		OP_ACQUIRE,
		OP_RELEASE,
		OP_SET_FREE,
		OP_DETECT
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [THREAD_W-1:0] thread;
		logic [RES_W-1:0]    res;
		logic [AMT_W-1:0]    amount;
		logic                t_ok;
		logic                r_ok;
	} cmd_t;

endpackage

@@ hw/rtl/rdd_ifs.sv @@
// Request, response and configuration channel interfaces.
interface rdd_req_if;
	import rdd_pkg::*;
	logic                valid;
	logic                ready;
	logic [TYPE_W-1:0]   req_type;
	logic [THREAD_W-1:0] thread_index;
	logic [RES_W-1:0]    resource_index;
	logic [AMT_W-1:0]    amount;
	modport source (output valid, req_type, thread_index, resource_index, amount,
		input ready);
	modport sink (input valid, req_type, thread_index, resource_index, amount,
		output ready);
endinterface

interface rdd_rsp_if;
	import rdd_pkg::*;
	logic               valid;
	logic               ready;
	logic               status;
	logic               deadlock_found;
	logic [MASK_W-1:0]  preempted_mask;
	logic [TOTAL_W-1:0] deadlock_total;
	modport source (output valid, status, deadlock_found, preempted_mask, deadlock_total,
		input ready);
	modport sink (input valid, status, deadlock_found, preempted_mask, deadlock_total,
		output ready);
endinterface

interface rdd_cfg_if;
	import rdd_pkg::*;
	logic                valid;
	logic                ready;
	logic [POLICY_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/rdd_front.sv @@
// Front end: accepts request items, decodes them and queues them for the back end.
module rdd_front #(
	parameter int THREADS        = 8,
	parameter int RESOURCE_TYPES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	rdd_req_if.sink       req,
	output logic          q_valid,
	output rdd_pkg::cmd_t q_cmd,
	input  logic          q_pop
);
	import rdd_pkg::*;

	cmd_t       dec;
	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	always_comb begin
		dec.thread = req.thread_index;
		dec.res    = req.resource_index;
		dec.amount = req.amount;
		dec.t_ok   = (32'(req.thread_index) < THREADS);
		dec.r_ok   = (32'(req.resource_index) < RESOURCE_TYPES);
		case (req.req_type)
			REQ_SET_NEED: dec.op = OP_SET_NEED;
			REQ_ACQUIRE:  dec.op = OP_ACQUIRE;
			REQ_RELEASE:  dec.op = OP_RELEASE;
			REQ_SET_FREE: dec.op = OP_SET_FREE;
			REQ_DETECT:   dec.op = OP_DETECT;
			default:      dec.op = OP_NONE;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_cmd     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/rdd_back.sv @@
// Back end: holds the tables, executes commands and runs detection with recovery.
module rdd_back #(
	parameter int THREADS        = 8,
	parameter int RESOURCE_TYPES = 4,
	parameter int UNIT_BITS      = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  rdd_pkg::cmd_t q_cmd,
	output logic          q_pop,
	rdd_rsp_if.source     rsp,
	rdd_cfg_if.sink       cfg
);
	import rdd_pkg::*;

	localparam int TW   = $clog2(THREADS);
	localparam int RW   = (RESOURCE_TYPES > 1) ? $clog2(RESOURCE_TYPES) : 1;
	localparam int UB   = UNIT_BITS;
	localparam int WW   = UNIT_BITS + $clog2(THREADS) + 1;
	localparam int SW   = UNIT_BITS + $clog2(RESOURCE_TYPES) + 1;
	localparam int UMAX = (1 << UNIT_BITS) - 1;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_INIT    = 7'b0000010,
		S_SCAN    = 7'b0000100,
		S_EVAL    = 7'b0001000,
		S_SELECT  = 7'b0010000,
		S_PREEMPT = 7'b0100000,
		S_FINISH  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [UB-1:0]      alloc_q [THREADS][RESOURCE_TYPES];
	logic [UB-1:0]      need_q  [THREADS][RESOURCE_TYPES];
	logic [UB-1:0]      free_q  [RESOURCE_TYPES];
	logic [WW-1:0]      work_q  [RESOURCE_TYPES];
	logic [THREADS-1:0] done_q;
	logic [THREADS-1:0] victim_q;
	logic [TW-1:0]      t_q;
	logic               progress_q;
	logic               found_q;
	logic [MASK_W-1:0]  mask_q;
	logic               have_q;
	logic [TW-1:0]      pick_q;
	logic [SW-1:0]      best_q;
	logic [POLICY_W-1:0] policy_q;
	logic [TOTAL_W-1:0] events_q;

	logic               rsp_v_q;
	logic               status_q;
	logic               found_out_q;
	logic [MASK_W-1:0]  mask_out_q;
	logic [TOTAL_W-1:0] total_q;

	logic [TW-1:0]      row_sel;
	logic [TW-1:0]      cmd_row;
	logic [RW-1:0]      cmd_res;
	logic [UB-1:0]      alloc_row [RESOURCE_TYPES];
	logic [UB-1:0]      need_row  [RESOURCE_TYPES];
	logic [THREADS-1:0] held;
	logic               amt_big;
	logic [UB-1:0]      amt_u;
	logic               acq_ok;
	logic               fits;
	logic               hit;
	logic               last_t;
	logic [SW-1:0]      row_val;
	logic               better;
	logic [TW-1:0]      pick_nx;
	logic               start;
	logic               pol_all;
	logic [TOTAL_W-1:0] events_nx;

	function automatic logic [UB-1:0] sat_add(input logic [UB-1:0] a, input logic [UB-1:0] b);
		logic [UB:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[UB] ? {UB{1'b1}} : s[UB-1:0];
	endfunction

	assign cfg.ready = 1'b1;
	assign cmd_row   = TW'(q_cmd.thread);
	assign cmd_res   = RW'(q_cmd.res);
	assign row_sel   = (state_q == S_IDLE) ? cmd_row : t_q;
	assign last_t    = (t_q == TW'(THREADS - 1));
	assign start     = (state_q == S_IDLE) && q_valid && (!rsp_v_q || rsp.ready);
	assign q_pop     = start;
	assign amt_big   = (32'(q_cmd.amount) > UMAX);
	assign amt_u     = amt_big ? {UB{1'b1}} : UB'(q_cmd.amount);
	assign pol_all   = (policy_q == POL_ALL) || (policy_q > POL_MIN_HOLD);
	assign events_nx = (found_q && events_q != {TOTAL_W{1'b1}}) ? events_q + 1'b1 : events_q;

	always_comb begin
		for (int r = 0; r < RESOURCE_TYPES; r++) begin
			alloc_row[r] = alloc_q[row_sel][r];
			need_row[r]  = need_q[row_sel][r];
		end
		for (int t = 0; t < THREADS; t++) begin
			held[t] = 1'b0;
			for (int r = 0; r < RESOURCE_TYPES; r++) begin
				held[t] = held[t] | (alloc_q[t][r] != '0);
			end
		end
	end

	always_comb begin
		fits    = 1'b1;
		row_val = '0;
		for (int r = 0; r < RESOURCE_TYPES; r++) begin
			if (WW'(need_row[r]) > work_q[r]) begin
				fits = 1'b0;
			end
			row_val = row_val + SW'(policy_q == POL_MAX_NEED ? need_row[r] : alloc_row[r]);
		end
		hit = !done_q[t_q] && fits;
		case (policy_q)
			POL_FIRST:    better = 1'b0;
			POL_MIN_HOLD: better = row_val < best_q;
			default:      better = row_val > best_q;
		endcase
		pick_nx = (!done_q[t_q] && (!have_q || better)) ? t_q : pick_q;
	end

	assign acq_ok = q_cmd.t_ok && q_cmd.r_ok && !amt_big && amt_u != '0 &&
		need_row[cmd_res] != '0 && amt_u <= need_row[cmd_res] && amt_u <= free_q[cmd_res];

	// tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < THREADS; t++) begin
				for (int r = 0; r < RESOURCE_TYPES; r++) begin
					alloc_q[t][r] <= '0;
					need_q[t][r]  <= '0;
				end
			end
			for (int r = 0; r < RESOURCE_TYPES; r++) begin
				free_q[r] <= '0;
			end
		end else begin
			if (start) begin
				case (q_cmd.op)
					OP_SET_NEED: begin
						if (q_cmd.t_ok && q_cmd.r_ok) begin
							need_q[cmd_row][cmd_res] <= amt_u;
						end
					end
					OP_ACQUIRE: begin
						if (acq_ok) begin
							alloc_q[cmd_row][cmd_res] <= alloc_row[cmd_res] + amt_u;
							need_q[cmd_row][cmd_res]  <= need_row[cmd_res] - amt_u;
							free_q[cmd_res]           <= free_q[cmd_res] - amt_u;
						end
					end
					OP_RELEASE: begin
						if (q_cmd.t_ok) begin
							for (int r = 0; r < RESOURCE_TYPES; r++) begin
								free_q[r]           <= sat_add(free_q[r], alloc_row[r]);
								alloc_q[cmd_row][r] <= '0;
							end
						end
					end
					OP_SET_FREE: begin
						if (q_cmd.r_ok) begin
							free_q[cmd_res] <= amt_u;
						end
					end
					default: begin
					end
				endcase
			end else if (state_q == S_PREEMPT && victim_q[t_q]) begin
				for (int r = 0; r < RESOURCE_TYPES; r++) begin
					need_q[t_q][r]  <= sat_add(need_row[r], alloc_row[r]);
					free_q[r]       <= sat_add(free_q[r], alloc_row[r]);
					alloc_q[t_q][r] <= '0;
				end
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			policy_q   <= POL_ALL;
			events_q   <= '0;
			rsp_v_q    <= 1'b0;
			t_q        <= '0;
			progress_q <= 1'b0;
			found_q    <= 1'b0;
			have_q     <= 1'b0;
			done_q     <= '0;
			victim_q   <= '0;
			mask_q     <= '0;
		end else begin
			if (cfg.valid) begin
				policy_q <= cfg.data;
			end
			// drop the taken result unless a new one replaces it now
			if (rsp_v_q && rsp.ready && !(start && q_cmd.op != OP_DETECT)) begin
				rsp_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (q_cmd.op == OP_DETECT) begin
							found_q <= 1'b0;
							mask_q  <= '0;
							state_q <= S_INIT;
						end else begin
							rsp_v_q     <= 1'b1;
							status_q    <= (q_cmd.op == OP_ACQUIRE) && !acq_ok;
							found_out_q <= 1'b0;
							mask_out_q  <= '0;
							total_q     <= events_q;
						end
					end
				end
				S_INIT: begin
					for (int r = 0; r < RESOURCE_TYPES; r++) begin
						work_q[r] <= WW'(free_q[r]);
					end
					done_q     <= ~held;
					t_q        <= '0;
					progress_q <= 1'b0;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					if (hit) begin
						done_q[t_q] <= 1'b1;
						for (int r = 0; r < RESOURCE_TYPES; r++) begin
							work_q[r] <= work_q[r] + WW'(alloc_row[r]);
						end
					end
					if (last_t) begin
						t_q        <= '0;
						progress_q <= 1'b0;
						// rescan while any thread finished on this pass
						if (!(progress_q || hit)) begin
							state_q <= S_EVAL;
						end
					end else begin
						t_q        <= t_q + 1'b1;
						progress_q <= progress_q | hit;
					end
				end
				S_EVAL: begin
					t_q <= '0;
					if (&done_q) begin
						state_q <= S_FINISH;
					end else begin
						found_q <= 1'b1;
						if (pol_all) begin
							victim_q <= ~done_q;
							state_q  <= S_PREEMPT;
						end else begin
							have_q  <= 1'b0;
							state_q <= S_SELECT;
						end
					end
				end
				S_SELECT: begin
					if (!done_q[t_q] && (!have_q || better)) begin
						best_q <= row_val;
						have_q <= 1'b1;
					end
					pick_q <= pick_nx;
					if (last_t) begin
						for (int t = 0; t < THREADS; t++) begin
							victim_q[t] <= (pick_nx == TW'(t));
						end
						t_q     <= '0;
						state_q <= S_PREEMPT;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				S_PREEMPT: begin
					if (victim_q[t_q]) begin
						for (int i = 0; i < MASK_W; i++) begin
							if (32'(t_q) == i) begin
								mask_q[i] <= 1'b1;
							end
						end
					end
					if (last_t) begin
						state_q <= S_INIT;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				S_FINISH: begin
					events_q    <= events_nx;
					rsp_v_q     <= 1'b1;
					status_q    <= 1'b0;
					found_out_q <= found_q;
					mask_out_q  <= mask_q;
					total_q     <= events_nx;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid          = rsp_v_q;
	assign rsp.status         = status_q;
	assign rsp.deadlock_found = found_out_q;
	assign rsp.preempted_mask = mask_out_q;
	assign rsp.deadlock_total = total_q;

endmodule

@@ hw/rtl/resource_deadlock_detector.sv @@
// Top level of the resource deadlock detector.
// Usage:
//   req carries one item per handshake: set need, acquire, release all,
//   set free units, or detect and recover. rsp returns exactly one item per
//   request item, in order. cfg writes the recovery policy; write it only
//   while no request is in flight. cfg.ready is always high.
// Throughput and sequencing:
//   Requests pass through a two-entry queue into the executor. Table
//   updates raise rsp.valid from the output register, one item a cycle
//   while rsp.ready stays high. Detect items run a sequencer that scans
//   one thread row per cycle: each detection round loads the work vector
//   from the free units, then sweeps the thread rows until no thread
//   finishes; a recovery round adds a selection pass unless the policy
//   takes all blocked threads, then a preemption pass; a final state posts the result.
// Reset:
//   arst_n clears all tables, the free units, the event counter and the
//   policy; the block accepts items as soon as reset is released.
// Stall:
//   A held result waits in the output register while the queue keeps
//   taking items; req.ready falls once both queue entries are full.
module resource_deadlock_detector #(
	parameter int THREADS        = 8,
	parameter int RESOURCE_TYPES = 4,
	parameter int UNIT_BITS      = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	rdd_req_if.sink   req,
	rdd_rsp_if.source rsp,
	rdd_cfg_if.sink   cfg
);
	import rdd_pkg::*;

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	rdd_front #(
		.THREADS        (THREADS),
		.RESOURCE_TYPES (RESOURCE_TYPES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	rdd_back #(
		.THREADS        (THREADS),
		.RESOURCE_TYPES (RESOURCE_TYPES),
		.UNIT_BITS      (UNIT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.rsp     (rsp),
		.cfg     (cfg)
	);

endmodule

@@ hw/rtl/rdd_checker.sv @@
// Port-level checks on the deadlock detector, bound to the top level.
module rdd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        status,
	input logic        deadlock_found,
	input logic [7:0]  preempted_mask,
	input logic [15:0] deadlock_total
);

	// a stalled result stays valid with its mask and total held
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(preempted_mask) &&
		$stable(deadlock_total))
		else $error("stalled result changed");

	a_mask_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !deadlock_found |-> preempted_mask == 8'd0)
		else $error("preemption reported without deadlock");

	a_denied_not_detect: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> !deadlock_found)
		else $error("denied item reported a deadlock");

	a_found_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && deadlock_found |-> deadlock_total != 16'd0)
		else $error("deadlock found but counter is zero");

endmodule

bind resource_deadlock_detector rdd_checker u_rdd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.deadlock_found (rsp.deadlock_found),
	.preempted_mask (rsp.preempted_mask),
	.deadlock_total (rsp.deadlock_total)
);
